[rtl/core/line_orientation_histogram_top_assert.svh]
// Assertion macros for the line orientation histogram.
`ifndef LINE_ORIENTATION_HISTOGRAM_TOP_ASSERT_SVH
`define LINE_ORIENTATION_HISTOGRAM_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LOH_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define LOH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/core/lohist_pkg.sv]
// ----------------------------------------------------------------------------
// lohist_pkg
// Shared types, codes and the arctangent table of the orientation histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package lohist_pkg;

  localparam int unsigned CoordW = 12;          // width of a coordinate field
  localparam int unsigned DiffW  = CoordW + 1;  // signed endpoint difference
  localparam int unsigned CordW  = DiffW + 16 + 3;
  localparam int unsigned AngW   = 18;          // signed CORDIC angle accumulator

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD      = 2'd1,
    OP_FINISH   = 2'd2,
    OP_CLASSIFY = 2'd3
  } op_e;

  // One decoded segment command handed from front to back.
  typedef struct packed {
    op_e                      op;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [5:0]  bin_index;
    logic [15:0] bin_count;
    logic [15:0] bin_fraction;
    logic [5:0]  dominant_bin;
    logic        is_vertical;
    logic        last;
  } res_t;

  // atan(2^-i) in units of pi/65536, rounded to nearest.
  function automatic logic [15:0] atan_unit(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd16384;
      4'd1:    v = 16'd9672;
      4'd2:    v = 16'd5110;
      4'd3:    v = 16'd2594;
      4'd4:    v = 16'd1302;
      4'd5:    v = 16'd652;
      4'd6:    v = 16'd326;
      4'd7:    v = 16'd163;
      4'd8:    v = 16'd81;
      4'd9:    v = 16'd41;
      4'd10:   v = 16'd20;
      4'd11:   v = 16'd10;
      4'd12:   v = 16'd5;
      4'd13:   v = 16'd3;
      default: v = 16'd1;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/lohist_front.sv]
// ----------------------------------------------------------------------------
// lohist_front
// Input stage: takes segment transfers, masks coordinates, forms dx and dy.
// ----------------------------------------------------------------------------
`default_nettype none

module lohist_front
  import lohist_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire op_e               op_i,
  input  wire logic [CoordW-1:0] start_x_i,
  input  wire logic [CoordW-1:0] start_y_i,
  input  wire logic [CoordW-1:0] end_x_i,
  input  wire logic [CoordW-1:0] end_y_i,
  output logic                   item_valid_o,
  input  wire logic              item_ready_i,
  output item_t                  item_o
);

  localparam int unsigned UseW = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam logic [CoordW-1:0] Mask = CoordW'((64'd1 << UseW) - 64'd1);

  logic  vld_q;
  item_t item_q, item_d;

  assign in_ready_o   = !vld_q || item_ready_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_comb begin
    item_d.op = op_i;
    item_d.dx = $signed({1'b0, end_x_i & Mask}) - $signed({1'b0, start_x_i & Mask});
    item_d.dy = $signed({1'b0, end_y_i & Mask}) - $signed({1'b0, start_y_i & Mask});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lohist_queue.sv]
// ----------------------------------------------------------------------------
// lohist_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lohist_queue
  import lohist_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_item_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output item_t      pop_item_o
);

  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

endmodule

`default_nettype wire

[rtl/core/lohist_back.sv]
// ----------------------------------------------------------------------------
// lohist_back
// Execution part: CORDIC orientation, bin memory, max sweep, fraction divide.
// ----------------------------------------------------------------------------
`default_nettype none

module lohist_back
  import lohist_pkg::*;
#(
  parameter int unsigned NUM_BINS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  output logic       item_ready_o,
  input  wire item_t item_i,
  output logic       res_valid_o,
  input  wire logic  res_ready_i,
  output res_t       res_o
);

  localparam int unsigned BW   = (NUM_BINS > 2) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned AngQ = 65536 / NUM_BINS;
  localparam int unsigned AngR = 65536 % NUM_BINS;
  localparam logic [BW-1:0] LastIdx = BW'(NUM_BINS - 1);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_CORDIC  = 12'b000000000010,
    S_ORIENT  = 12'b000000000100,
    S_ADD_RD  = 12'b000000001000,
    S_ADD_WR  = 12'b000000010000,
    S_MAX_RD  = 12'b000000100000,
    S_MAX_USE = 12'b000001000000,
    S_COMMIT  = 12'b000010000000,
    S_EMIT_RD = 12'b000100000000,
    S_DIV     = 12'b001000000000,
    S_EMIT    = 12'b010000000000,
    S_CLASS   = 12'b100000000000
  } state_e;

  state_e                   state_q;
  op_e                      op_q;
  logic signed [CordW-1:0]  x_q, y_q, xs, ys;
  logic signed [AngW-1:0]   z_q;
  logic [3:0]               it_q;
  logic                     sp_q, pos_q, zero_q;
  logic [15:0]              a_q, a_v, theta_q;
  logic [16:0]              th_v;
  logic [22:0]              prod;
  logic [BW-1:0]            bin_q, bin_v, idx_q, best_q;
  logic [15:0]              max_q, cnt_q;
  logic [15:0]              ang_q, best_ang_q, dom_ang_q;
  logic [BW:0]              arem_q;
  logic [BW+1:0]            arem_v;
  logic [5:0]               dom_idx_q;
  logic [16:0]              rem_q, rem2;
  logic [15:0]              nlo_q, quo_q, d_v;
  logic [NUM_BINS-1:0]      vld_q;
  logic [15:0]              mem_q [NUM_BINS];
  logic [15:0]              rd_data_q, rd_cnt;
  logic                     rd_vld_q;
  logic [BW-1:0]            rd_addr;
  logic                     we;
  logic                     out_free;
  logic                     emit_go;
  logic                     out_vld_q;
  res_t                     res_q;
  logic signed [DiffW-1:0]  adx, ady;

  assign item_ready_o = (state_q == S_IDLE);
  assign res_valid_o  = out_vld_q;
  assign res_o        = res_q;
  assign out_free     = !out_vld_q || res_ready_i;
  // a new result is loaded into the output register this cycle
  assign emit_go      = out_free && ((state_q == S_EMIT) || (state_q == S_CLASS));

  assign adx = item_i.dx[DiffW-1] ? -item_i.dx : item_i.dx;
  assign ady = item_i.dy[DiffW-1] ? -item_i.dy : item_i.dy;
  assign xs  = x_q >>> it_q;
  assign ys  = y_q >>> it_q;

  // Orientation from the CORDIC angle, or from a fixed angle for axis-aligned segments
  always_comb begin
    if (sp_q)                        a_v = a_q;
    else if (z_q[AngW-1])            a_v = 16'd0;
    else if (z_q > AngW'(32768))     a_v = 16'd32768;
    else                             a_v = z_q[15:0];
    th_v  = pos_q ? 17'd32768 + 17'(a_v) : 17'd32768 - 17'(a_v);
    prod  = 23'((th_v[16] ? 16'hFFFF : th_v[15:0])) * 23'(NUM_BINS);
    bin_v = (prod[22:16] >= 7'(NUM_BINS)) ? LastIdx : prod[BW+15:16];
  end

  assign rd_addr = (state_q == S_ADD_RD) ? bin_q : idx_q;
  assign rd_cnt  = rd_vld_q ? rd_data_q : 16'd0;
  assign we      = (state_q == S_ADD_WR) && (rd_cnt != 16'hFFFF);
  assign rem2    = {rem_q[15:0], nlo_q[15]};
  assign arem_v  = (BW+2)'(arem_q) + (BW+2)'(AngR);
  assign d_v     = theta_q - dom_ang_q;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[bin_q] <= rd_cnt + 16'd1;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      dom_idx_q  <= 6'd0;
      dom_ang_q  <= 16'd0;
      op_q       <= OP_CLEAR;
      x_q <= '0; y_q <= '0; z_q <= '0; it_q <= '0;
      sp_q <= 1'b0; pos_q <= 1'b0; zero_q <= 1'b0;
      a_q <= '0; theta_q <= '0; bin_q <= '0; idx_q <= '0; best_q <= '0;
      max_q <= '0; cnt_q <= '0; ang_q <= '0; best_ang_q <= '0; arem_q <= '0;
      rem_q <= '0; nlo_q <= '0; quo_q <= '0;
      res_q <= '0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      if (res_ready_i && !emit_go) out_vld_q <= 1'b0;
      if (we) vld_q[bin_q] <= 1'b1;

      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            op_q   <= item_i.op;
            pos_q  <= (item_i.dx > 0) == (item_i.dy >= 0);
            zero_q <= (item_i.dx == 0) && (item_i.dy == 0);
            x_q    <= CordW'(ady) <<< 16;
            y_q    <= CordW'(adx) <<< 16;
            z_q    <= '0;
            it_q   <= '0;
            sp_q   <= (item_i.dx == 0) || (item_i.dy == 0);
            a_q    <= (item_i.dy == 0) ? 16'd32768 : 16'd0;
            idx_q  <= '0;
            max_q  <= '0;
            best_q <= '0;
            ang_q  <= '0;
            arem_q <= '0;
            best_ang_q <= '0;
            case (item_i.op)
              OP_CLEAR: vld_q <= '0;
              OP_FINISH: state_q <= S_MAX_RD;
              default: begin
                if (item_i.dx == 0 && item_i.dy == 0) begin
                  bin_q   <= '0;
                  state_q <= (item_i.op == OP_ADD) ? S_IDLE : S_CLASS;
                end else if (item_i.dx == 0 || item_i.dy == 0) begin
                  state_q <= S_ORIENT;
                end else begin
                  state_q <= S_CORDIC;
                end
              end
            endcase
          end
        end
        S_CORDIC: begin
          if (y_q > 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + AngW'(atan_unit(it_q));
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - AngW'(atan_unit(it_q));
          end
          it_q <= it_q + 4'd1;
          if (it_q == 4'd15) state_q <= S_ORIENT;
        end
        S_ORIENT: begin
          theta_q <= th_v[16] ? 16'hFFFF : th_v[15:0];
          bin_q   <= bin_v;
          state_q <= (op_q == OP_ADD) ? S_ADD_RD : S_CLASS;
        end
        S_ADD_RD: state_q <= S_ADD_WR;
        S_ADD_WR: state_q <= S_IDLE;
        S_MAX_RD: state_q <= S_MAX_USE;
        S_MAX_USE: begin
          if (rd_cnt > max_q) begin
            max_q      <= rd_cnt;
            best_q     <= idx_q;
            best_ang_q <= ang_q;
          end
          // running floor(idx * 65536 / NUM_BINS)
          if (arem_v >= (BW+2)'(NUM_BINS)) begin
            arem_q <= (BW+1)'(arem_v - (BW+2)'(NUM_BINS));
            ang_q  <= ang_q + 16'(AngQ) + 16'd1;
          end else begin
            arem_q <= (BW+1)'(arem_v);
            ang_q  <= ang_q + 16'(AngQ);
          end
          idx_q   <= idx_q + 1'b1;
          state_q <= (idx_q == LastIdx) ? S_COMMIT : S_MAX_RD;
        end
        S_COMMIT: begin
          if (max_q != 16'd0) begin
            dom_idx_q <= 6'(best_q);
            dom_ang_q <= best_ang_q;
          end
          idx_q   <= '0;
          state_q <= S_EMIT_RD;
        end
        S_EMIT_RD: begin
          // registered read lands next cycle; load divider in S_DIV entry
          state_q <= S_DIV;
          it_q    <= '0;
          sp_q    <= 1'b1;
        end
        S_DIV: begin
          if (sp_q) begin
            sp_q  <= 1'b0;
            cnt_q <= rd_cnt;
            rem_q <= {2'b0, rd_cnt[15:1]};
            nlo_q <= {rd_cnt[0], 15'd0};
            quo_q <= '0;
            if (max_q == 16'd0) state_q <= S_EMIT;
          end else begin
            if (rem2 >= {1'b0, max_q}) begin
              rem_q <= rem2 - {1'b0, max_q};
              quo_q <= {quo_q[14:0], 1'b1};
            end else begin
              rem_q <= rem2;
              quo_q <= {quo_q[14:0], 1'b0};
            end
            nlo_q <= {nlo_q[14:0], 1'b0};
            it_q  <= it_q + 4'd1;
            if (it_q == 4'd15) state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_vld_q          <= 1'b1;
            res_q.bin_index    <= 6'(idx_q);
            res_q.bin_count    <= cnt_q;
            res_q.bin_fraction <= quo_q;
            res_q.dominant_bin <= dom_idx_q;
            res_q.is_vertical  <= 1'b0;
            res_q.last         <= (idx_q == LastIdx);
            idx_q              <= idx_q + 1'b1;
            state_q            <= (idx_q == LastIdx) ? S_IDLE : S_EMIT_RD;
          end
        end
        S_CLASS: begin
          if (out_free) begin
            out_vld_q          <= 1'b1;
            res_q.bin_index    <= 6'(bin_q);
            res_q.bin_count    <= 16'd0;
            res_q.bin_fraction <= 16'd0;
            res_q.dominant_bin <= dom_idx_q;
            res_q.is_vertical  <= !zero_q && ((d_v < 16'd16384) || (d_v > 16'd49152));
            res_q.last         <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/line_orientation_histogram_top.sv]
// Line orientation histogram. Each segment transfer carries two endpoints and
// a command in tuser: clear, add, finish or classify. Add and classify run a
// 16-step CORDIC (one step per cycle) unless the segment is axis-aligned or
// of zero length. Finish sweeps the bin memory twice, once for the maximum
// and once to emit each bin with a restoring divide for the Q1.15 fraction.
// A two-entry queue after the input register lets new transfers be taken while
// the back part works; one output register holds the result being offered.
// ----------------------------------------------------------------------------
// line_orientation_histogram_top
// Top level: input stage, command queue and execution back part.
// ----------------------------------------------------------------------------
`default_nettype none

module line_orientation_histogram_top
  import lohist_pkg::*;
#(
  parameter int unsigned NUM_BINS   = 32,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36]
  input  wire logic [47:0] s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // bin_index[5:0], bin_count[21:6], bin_fraction[37:22], dominant_bin[43:38],
  // is_vertical[44], zero[47:45]
  output logic [47:0]      m_axis_tdata,
  // last result of one command
  output logic             m_axis_tlast
);

  item_t fr_item, q_item;
  logic  fr_valid, fr_ready, q_valid, q_ready;
  res_t  res;

  lohist_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (op_e'(s_axis_tuser)),
    .start_x_i    (s_axis_tdata[11:0]),
    .start_y_i    (s_axis_tdata[23:12]),
    .end_x_i      (s_axis_tdata[35:24]),
    .end_y_i      (s_axis_tdata[47:36]),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  // decouples command intake from the long-running back part
  lohist_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  lohist_back #(.NUM_BINS(NUM_BINS)) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {3'b000, res.is_vertical, res.dominant_bin, res.bin_fraction,
                         res.bin_count, res.bin_index};
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

[rtl/core/lohist_checker.sv]
// ----------------------------------------------------------------------------
// lohist_checker
// Port-level checks on the orientation histogram, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_orientation_histogram_top_assert.svh"

module lohist_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [47:0] s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  `LOH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

  `LOH_ASSERT_NOW(a_frac_range, m_axis_tvalid, m_axis_tdata[37:22] <= 16'd32768, "fraction above one")

  `LOH_ASSERT_NOW(a_empty_frac, m_axis_tvalid && (m_axis_tdata[21:6] == 16'd0), m_axis_tdata[37:22] == 16'd0, "nonzero fraction for empty bin")

  `LOH_ASSERT_NOW(a_vert_single, m_axis_tvalid && m_axis_tdata[44], m_axis_tlast && (m_axis_tdata[21:6] == 16'd0), "vertical flag outside a classify result")

endmodule

bind line_orientation_histogram_top lohist_checker u_lohist_checker (.*);

`default_nettype wire
